// File: hw/rtl/qse_pkg.sv
`timescale 1ns / 1ps
package qse_pkg;

    localparam int QSE_DEPTH   = 64;
    localparam int QSE_VALUE_W = 32;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_POP_WAIT,
        S_PIV,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_W1,
        S_SWAP_W2,
        S_FIN_RD,
        S_FIN_W1,
        S_FIN_W2,
        S_PUSH_HI,
        S_PUSH_LO,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_WAIT
    } t_state;

endpackage

// File: hw/rtl/qse_if.sv
`timescale 1ns / 1ps
interface qse_in_if;
    import qse_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [QSE_VALUE_W-1:0]  in_value;
    logic                           in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface qse_out_if;
    import qse_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [QSE_VALUE_W-1:0]  out_value;
    logic                           out_last;
    logic                           out_overflow;

    modport source (output valid, output out_value, output out_last, output out_overflow,
                    input ready);
    modport sink   (input valid, input out_value, input out_last, input out_overflow,
                    output ready);
endinterface

// File: hw/rtl/quicksort_sort_engine.sv
`timescale 1ns / 1ps
// Sort engine: collects signed 32-bit values and returns them in ascending order.
// i_item (valid/ready sink) takes one value per cycle while the engine is loading;
// the item with in_last set closes the set. Up to DEPTH values are kept; further
// values are dropped and every result of that set carries out_overflow.
// After the closing item the engine sorts in place with Lomuto quicksort, using
// a range stack held in a second memory. ready stays low from the closing item
// until the final result has been taken.
// o_result (valid/ready source) then returns each value from a registered stage,
// out_last set on the greatest one. The set count and overflow flag then clear.
// Each partition step reads and compares every scanned entry, writes both entries of
// each swap, and ends each range by placing the pivot and pushing its subranges;
// each result is read from the element memory, which has a single read port.
// Presorted or all-equal sets are the worst case for this choice of pivot.
// A stalled receiver holds the current result and freezes the engine.
// Reset (i_rst_n low, synchronous) returns to loading with an empty set; the
// memories need no clearing since only entries written in the current set are read.
module quicksort_sort_engine #(
    parameter int DEPTH = qse_pkg::QSE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qse_in_if.sink     i_item,
    qse_out_if.source  o_result
);
    import qse_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SA_W  = $clog2(DEPTH + 1);
    localparam int TOP_W = $clog2(DEPTH + 2);
    localparam int SK_W  = 2 * IDX_W;

    t_state r_state, n_state;

    logic signed [QSE_VALUE_W-1:0] r_store [DEPTH];
    logic signed [QSE_VALUE_W-1:0] r_rd_value;
    logic [SK_W-1:0]               r_stack [DEPTH + 1];
    logic [SK_W-1:0]               r_stk_rd;

    logic [CNT_W-1:0]              r_count;
    logic                          r_dropped;
    logic [TOP_W-1:0]              r_top;
    logic [IDX_W-1:0]              r_lo, r_hi, r_j, r_place, r_k;
    logic signed [QSE_VALUE_W-1:0] r_pivot, r_aj;

    logic                          r_out_valid;
    logic signed [QSE_VALUE_W-1:0] r_out_value;
    logic                          r_out_last;
    logic                          r_out_ovf;

    logic                          st_we;
    logic [IDX_W-1:0]              st_waddr, st_raddr;
    logic signed [QSE_VALUE_W-1:0] st_wdata;
    logic                          sk_we;
    logic [SA_W-1:0]               sk_waddr, sk_raddr;
    logic [SK_W-1:0]               sk_wdata;

    logic                          accept;
    logic                          store_full;
    logic [IDX_W-1:0]              pop_lo, pop_hi;
    logic                          scan_end;
    logic                          stk_room;
    logic                          push_hi_ok, push_lo_ok;
    logic                          out_end;

    assign accept     = i_item.valid && i_item.ready;
    assign store_full = (r_count == CNT_W'(DEPTH));
    assign pop_lo     = r_stk_rd[SK_W-1:IDX_W];
    assign pop_hi     = r_stk_rd[IDX_W-1:0];
    assign scan_end   = (CNT_W'(r_j) + 1'b1 == CNT_W'(r_hi));
    assign stk_room   = (r_top < TOP_W'(DEPTH + 1));
    assign push_hi_ok = (CNT_W'(r_place) + 1'b1 < CNT_W'(r_hi)) && stk_room;
    assign push_lo_ok = (CNT_W'(r_place) > CNT_W'(r_lo) + 1'b1) && stk_room;
    assign out_end    = (CNT_W'(r_k) + 1'b1 == r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (accept && i_item.in_last) begin
                    if (r_count == '0) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT:     n_state = S_POP;
            S_POP: begin
                if (r_top == '0) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                if (pop_lo >= pop_hi) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PIV;
                end
            end
            S_PIV:      n_state = S_SCAN_CMP;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (r_rd_value <= r_pivot) begin
                    n_state = S_SWAP_W1;
                end else if (scan_end) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SWAP_W1:  n_state = S_SWAP_W2;
            S_SWAP_W2: begin
                if (scan_end) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_FIN_RD:   n_state = S_FIN_W1;
            S_FIN_W1:   n_state = S_FIN_W2;
            S_FIN_W2:   n_state = S_PUSH_HI;
            S_PUSH_HI:  n_state = S_PUSH_LO;
            S_PUSH_LO:  n_state = S_POP;
            S_OUT_RD:   n_state = S_OUT_LOAD;
            S_OUT_LOAD: n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (o_result.ready) begin
                    if (r_out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        i_item.ready = 1'b0;
        st_we        = 1'b0;
        st_waddr     = r_j;
        st_wdata     = r_rd_value;
        st_raddr     = r_j;
        sk_we        = 1'b0;
        sk_waddr     = SA_W'(r_top);
        sk_wdata     = {r_lo, r_hi};
        sk_raddr     = SA_W'(r_top - 1'b1);
        unique case (r_state)
            S_LOAD: begin
                i_item.ready = 1'b1;
                st_we        = i_item.valid && !store_full;
                st_waddr     = IDX_W'(r_count);
                st_wdata     = i_item.in_value;
            end
            S_INIT: begin
                sk_we    = 1'b1;
                sk_waddr = '0;
                sk_wdata = {IDX_W'(0), IDX_W'(r_count - 1'b1)};
            end
            S_POP_WAIT: st_raddr = pop_hi;
            S_PIV:      st_raddr = r_lo;
            S_SCAN_RD:  st_raddr = r_j;
            S_SCAN_CMP: st_raddr = r_place;
            S_SWAP_W1: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = r_rd_value;
            end
            S_SWAP_W2: begin
                st_we    = 1'b1;
                st_waddr = r_place;
                st_wdata = r_aj;
            end
            S_FIN_RD:   st_raddr = r_place;
            S_FIN_W1: begin
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = r_rd_value;
            end
            S_FIN_W2: begin
                st_we    = 1'b1;
                st_waddr = r_place;
                st_wdata = r_pivot;
            end
            S_PUSH_HI: begin
                sk_we    = push_hi_ok;
                sk_wdata = {r_place + 1'b1, r_hi};
            end
            S_PUSH_LO: begin
                sk_we    = push_lo_ok;
                sk_wdata = {r_lo, r_place - 1'b1};
            end
            S_OUT_RD:   st_raddr = r_k;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        r_rd_value <= r_store[st_raddr];
        if (sk_we) begin
            r_stack[sk_waddr] <= sk_wdata;
        end
        r_stk_rd <= r_stack[sk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (store_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_k <= '0;
                end
                S_INIT:     r_top <= TOP_W'(1);
                S_POP: begin
                    if (r_top != '0) begin
                        r_top <= r_top - 1'b1;
                    end
                    r_k <= '0;
                end
                S_POP_WAIT: begin
                    r_lo <= pop_lo;
                    r_hi <= pop_hi;
                end
                S_PIV: begin
                    r_pivot <= r_rd_value;
                    r_place <= r_lo;
                    r_j     <= r_lo;
                end
                S_SCAN_CMP: begin
                    if (r_rd_value <= r_pivot) begin
                        r_aj <= r_rd_value;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_SWAP_W2: begin
                    r_place <= r_place + 1'b1;
                    r_j     <= r_j + 1'b1;
                end
                S_PUSH_HI: begin
                    if (push_hi_ok) begin
                        r_top <= r_top + 1'b1;
                    end
                end
                S_PUSH_LO: begin
                    if (push_lo_ok) begin
                        r_top <= r_top + 1'b1;
                    end
                end
                S_OUT_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= r_rd_value;
                    r_out_last  <= out_end;
                    r_out_ovf   <= r_dropped;
                end
                S_OUT_WAIT: begin
                    if (o_result.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_value    = r_out_value;
    assign o_result.out_last     = r_out_last;
    assign o_result.out_overflow = r_out_ovf;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import qse_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 280;
    localparam int TAIL_CYCLES  = 40;

    typedef enum {FILL_WIDE, FILL_NARROW, FILL_RISING, FILL_FALLING, FILL_FLAT, FILL_EDGES} t_fill;

    typedef struct {
        logic signed [QSE_VALUE_W-1:0] value;
        logic                          last;
        logic                          overflow;
    } t_sorted_word;

    logic i_clk;
    logic i_rst_n;

    qse_in_if  item_if ();
    qse_out_if res_if ();

    quicksort_sort_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    logic signed [QSE_VALUE_W-1:0] held_values[$];
    logic                          dropped_seen;
    t_sorted_word                  pending_sorted[$];

    bit full_rate;
    int cycles;
    int mismatches;
    int items_taken;
    int sets_closed;
    int overflow_sets;
    int words_checked;

    always #1 i_clk = ~i_clk;

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Store the value or flag the drop; on the closing item queue the sorted set.
    task automatic absorb_value(input logic signed [QSE_VALUE_W-1:0] v, input logic l);
        logic signed [QSE_VALUE_W-1:0] key;
        t_sorted_word                  w;
        int                            i;
        int                            j;
        if (held_values.size() < QSE_DEPTH) begin
            held_values.push_back(v);
        end else begin
            dropped_seen = 1'b1;
        end
        if (l) begin
            for (i = 1; i < held_values.size(); i++) begin
                key = held_values[i];
                j = i - 1;
                while (j >= 0 && held_values[j] > key) begin
                    held_values[j+1] = held_values[j];
                    j--;
                end
                held_values[j+1] = key;
            end
            for (i = 0; i < held_values.size(); i++) begin
                w.value    = held_values[i];
                w.last     = (i == held_values.size() - 1);
                w.overflow = dropped_seen;
                pending_sorted.push_back(w);
            end
            sets_closed++;
            if (dropped_seen) begin
                overflow_sets++;
            end
            held_values.delete();
            dropped_seen = 1'b0;
        end
    endtask

    // Call at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic signed [QSE_VALUE_W-1:0] v, input logic l);
        while (!full_rate && $urandom_range(0, 99) < 20) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid    <= 1'b1;
        item_if.in_value <= v;
        item_if.in_last  <= l;
        @(posedge i_clk);
        while (!item_if.ready) begin
            @(posedge i_clk);
        end
        items_taken++;
        absorb_value(v, l);
    endtask

    task automatic send_set(input int n, input t_fill fill);
        logic signed [QSE_VALUE_W-1:0] base;
        logic signed [QSE_VALUE_W-1:0] v;
        int                            k;
        base = $urandom;
        for (k = 0; k < n; k++) begin
            case (fill)
                FILL_WIDE:    v = $urandom;
                FILL_NARROW:  v = $signed($urandom_range(0, 6)) - 3;
                FILL_RISING:  v = base + k;
                FILL_FALLING: v = base - k;
                FILL_FLAT:    v = base;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7fff_ffff;
                        2:       v = 32'sd0;
                        default: v = -32'sd1;
                    endcase
                end
            endcase
            send_item(v, k == n - 1);
        end
    endtask

    task automatic test_single_items();
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b1);
    endtask

    task automatic test_duplicates();
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
    endtask

    task automatic test_ordered_runs();
        send_set(4, FILL_RISING);
        send_set(4, FILL_FALLING);
        send_set(2, FILL_FLAT);
    endtask

    // Exactly full, then full with the closing item dropped.
    task automatic test_store_limits();
        send_set(QSE_DEPTH, FILL_RISING);
        send_set(QSE_DEPTH + 2, FILL_WIDE);
    endtask

    task automatic test_back_to_back();
        full_rate = 1'b1;
        send_set(20, FILL_WIDE);
        send_set(12, FILL_NARROW);
        send_set(1, FILL_EDGES);
        full_rate = 1'b0;
    endtask

    task automatic test_random_sets(input int budget);
        int stop_at;
        int pick;
        int n;
        stop_at = items_taken + budget;
        while (items_taken < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n = $urandom_range(1, 12);
            end else if (pick < 86) begin
                n = $urandom_range(13, 40);
            end else if (pick < 93) begin
                n = QSE_DEPTH;
            end else begin
                n = $urandom_range(QSE_DEPTH + 1, QSE_DEPTH + 6);
            end
            send_set(n, t_fill'($urandom_range(0, 5)));
        end
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= full_rate || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_sorted.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            words_checked++;
            if (pending_sorted.size() == 0) begin
                log_mismatch($sformatf("unexpected result value %0d last %0b overflow %0b",
                                       res_if.out_value, res_if.out_last,
                                       res_if.out_overflow));
            end else begin
                w = pending_sorted.pop_front();
                if (res_if.out_value !== w.value || res_if.out_last !== w.last ||
                    res_if.out_overflow !== w.overflow) begin
                    log_mismatch($sformatf(
                        "expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                        w.value, w.last, w.overflow,
                        res_if.out_value, res_if.out_last, res_if.out_overflow));
                end
            end
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        item_if.valid    = 1'b0;
        item_if.in_value = '0;
        item_if.in_last  = 1'b0;
        res_if.ready     = 1'b0;
        dropped_seen     = 1'b0;
        full_rate        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_items();
        test_extreme_values();
        test_duplicates();
        test_ordered_runs();
        test_back_to_back();
        test_store_limits();
        test_random_sets(RANDOM_ITEMS - items_taken);

        item_if.valid <= 1'b0;
        while (pending_sorted.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items in %0d sets, %0d of them overflowed the store",
                 items_taken, sets_closed, overflow_sets);
        $display("checked %0d sorted words in %0d cycles, %0d mismatches",
                 words_checked, cycles, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: quicksort_sort_engine.f
hw/rtl/qse_pkg.sv
hw/rtl/qse_if.sv
hw/rtl/quicksort_sort_engine.sv
test/tb_top.sv
